/* sv/pcomp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcomp_pkg: shared constants and helpers for the pressure/temperature block
// Field widths, register indexes, formula constants and sign helpers.
// ----------------------------------------------------------------------------
package pcomp_pkg;

    localparam int WORD_W  = 64;
    localparam int ADC_W   = 20;
    localparam int TEMP_W  = 16;
    localparam int PRESS_W = 24;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_TEMP_CAL   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_HIGH = 2'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_NINE = 2'd3;

    localparam logic [ADC_W-1:0]  ADC_REJECT  = 20'h80000;
    localparam logic [TEMP_W-1:0] TEMP_RESET  = 16'h8000;
    localparam logic [63:0]       FINE_OFFSET = 64'd128000;
    localparam logic [63:0]       PRESS_BIAS  = 64'd1048576;
    localparam logic [63:0]       PRESS_SCALE = 64'd3125;
    localparam logic [63:0]       ROUND_HALF  = 64'd128;
    localparam logic [63:0]       DIV_BASE    = 64'h0000_8000_0000_0000;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] v, input int n);
        return 64'($signed(v) >>> n);
    endfunction

endpackage

/* sv/pcomp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcomp_in_if: raw sample channel
// Valid/ready channel carrying one raw pressure and temperature pair.
// ----------------------------------------------------------------------------
interface pcomp_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcomp_pkg::ADC_W-1:0]    adc_pressure;
    logic [pcomp_pkg::ADC_W-1:0]    adc_temperature;

    modport source (output valid, output adc_pressure, output adc_temperature,
                    input ready);
    modport sink   (input valid, input adc_pressure, input adc_temperature,
                    output ready);
endinterface

/* sv/pcomp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcomp_out_if: compensated result channel
// Valid/ready channel carrying held temperature, pressure and status flags.
// ----------------------------------------------------------------------------
interface pcomp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pcomp_pkg::TEMP_W-1:0]  temperature_centi;
    logic [pcomp_pkg::PRESS_W-1:0]        pressure_pa;
    logic                                 pressure_known;
    logic                                 sample_rejected;
    logic                                 divide_fault;

    modport source (output valid, output temperature_centi, output pressure_pa,
                    output pressure_known, output sample_rejected,
                    output divide_fault, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa,
                    input pressure_known, input sample_rejected,
                    input divide_fault, output ready);
endinterface

/* sv/pcomp_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcomp_mul: bit-serial multiplier
// Shift-and-add product modulo 2^W, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pcomp_mul #(
    parameter int W = pcomp_pkg::WORD_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    output logic         done,
    output logic [W-1:0] product
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] mcand_reg, mcand_next;
    logic [W-1:0] mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = op_a;
            mplier_next = op_b;
        end
        else if (busy_reg)
        begin
            acc_next    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
            mcand_next  = {mcand_reg[W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[W-1:1]};
            // stop once no set bits remain
            if (mplier_reg[W-1:1] == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* sv/pcomp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcomp_div: bit-serial signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pcomp_div #(
    parameter int W = pcomp_pkg::WORD_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] numer,
    input  logic [W-1:0] denom,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     mb_reg, mb_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, mb_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = numer[W-1] ^ denom[W-1];
            rem_next  = '0;
            quo_next  = numer[W-1] ? (~numer + 1'b1) : numer;
            mb_next   = denom[W-1] ? (~denom + 1'b1) : denom;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

/* sv/pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation: integer barometer compensation
// Raw pressure/temperature pair in, held temperature and pressure out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw pair per item; out_ch returns exactly one result
//   item per input item: held temperature (0.01 C), held pressure (Pa) and
//   the known/rejected/fault flags. Calibration is written through
//   cfg_we/cfg_index/cfg_data while the block is idle; the block itself
//   does not enforce this, so the user must keep to it.
// Sequencing:
//   One item at a time. A rejected sample goes from acceptance to S_DONE
//   and from there into the output register. Otherwise the item runs
//   through 13 products on one bit-serial multiplier (each a start, one
//   step per multiplier bit up to its highest set bit, and a done) and one
//   serial divide. A zero divisor skips the divide and the last four
//   products. in_ch.ready is high only while the sequencer is idle, so the
//   next item is taken only after the last one has left S_DONE.
// Reset:
//   Calibration clears to zero, temperature holds 0x8000, pressure holds 0
//   and pressure_known is low.
// Stall:
//   The result sits in an output register; the sequencer may take the next
//   item meanwhile and waits only if a second result finds the register full.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    pcomp_in_if.sink                      in_ch,
    pcomp_out_if.source                   out_ch,
    input  logic                          cfg_we,
    input  logic [pcomp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pcomp_pkg::CFG_W-1:0]   cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M1   = 5'd1;
    localparam logic [4:0] S_M2   = 5'd2;
    localparam logic [4:0] S_M3   = 5'd3;
    localparam logic [4:0] S_TEMP = 5'd4;
    localparam logic [4:0] S_M4   = 5'd5;
    localparam logic [4:0] S_M5   = 5'd6;
    localparam logic [4:0] S_M6   = 5'd7;
    localparam logic [4:0] S_M7   = 5'd8;
    localparam logic [4:0] S_M8   = 5'd9;
    localparam logic [4:0] S_M9   = 5'd10;
    localparam logic [4:0] S_CHK  = 5'd11;
    localparam logic [4:0] S_M10  = 5'd12;
    localparam logic [4:0] S_DIV  = 5'd13;
    localparam logic [4:0] S_M11  = 5'd14;
    localparam logic [4:0] S_M12  = 5'd15;
    localparam logic [4:0] S_M13  = 5'd16;
    localparam logic [4:0] S_FIN1 = 5'd17;
    localparam logic [4:0] S_FIN2 = 5'd18;
    localparam logic [4:0] S_DONE = 5'd19;

    localparam int WORD_W  = pcomp_pkg::WORD_W;
    localparam int ADC_W   = pcomp_pkg::ADC_W;
    localparam int TEMP_W  = pcomp_pkg::TEMP_W;
    localparam int PRESS_W = pcomp_pkg::PRESS_W;

    // calibration registers
    logic [47:0] temp_cal_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    // sequencer and working registers
    logic [4:0]         state_reg, state_next;
    logic               issued_reg, issued_next;
    logic [ADC_W-1:0]   adc_p_reg, adc_p_next;
    logic [ADC_W-1:0]   adc_t_reg, adc_t_next;
    logic               rej_reg, rej_next;
    logic               fault_reg, fault_next;
    logic [WORD_W-1:0]  x_reg, x_next;
    logic [WORD_W-1:0]  y_reg, y_next;
    logic [WORD_W-1:0]  z_reg, z_next;
    logic [WORD_W-1:0]  w_reg, w_next;
    logic [WORD_W-1:0]  q_reg, q_next;
    logic [WORD_W-1:0]  fine_reg, fine_next;

    // held state
    logic [TEMP_W-1:0]  held_t_reg, held_t_next;
    logic [PRESS_W-1:0] held_p_reg, held_p_next;
    logic               seen_reg, seen_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    logic [TEMP_W-1:0]  o_t_reg, o_t_next;
    logic [PRESS_W-1:0] o_p_reg, o_p_next;
    logic               o_known_reg, o_known_next;
    logic               o_rej_reg, o_rej_next;
    logic               o_fault_reg, o_fault_next;

    // arithmetic units
    logic               mul_start, mul_done;
    logic [WORD_W-1:0]  mul_a, mul_b, mul_p;
    logic               div_start, div_done;
    logic [WORD_W-1:0]  div_q;
    logic               is_mul;

    // unpacked coefficients
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a_t, b_t, q13, temp_sum, fin_sum, press_sum;

    assign t1 = {48'd0, temp_cal_reg[15:0]};
    assign t2 = pcomp_pkg::sx16(temp_cal_reg[31:16]);
    assign t3 = pcomp_pkg::sx16(temp_cal_reg[47:32]);
    assign p1 = {48'd0, press_low_reg[15:0]};
    assign p2 = pcomp_pkg::sx16(press_low_reg[31:16]);
    assign p3 = pcomp_pkg::sx16(press_low_reg[47:32]);
    assign p4 = pcomp_pkg::sx16(press_low_reg[63:48]);
    assign p5 = pcomp_pkg::sx16(press_high_reg[15:0]);
    assign p6 = pcomp_pkg::sx16(press_high_reg[31:16]);
    assign p7 = pcomp_pkg::sx16(press_high_reg[47:32]);
    assign p8 = pcomp_pkg::sx16(press_high_reg[63:48]);
    assign p9 = pcomp_pkg::sx16(press_nine_reg);

    assign a_t       = {47'd0, adc_t_reg[19:3]} - {t1[62:0], 1'b0};
    assign b_t       = {48'd0, adc_t_reg[19:4]} - t1;
    assign q13       = pcomp_pkg::asr(q_reg, 13);
    assign temp_sum  = {fine_reg[61:0], 2'b00} + fine_reg + pcomp_pkg::ROUND_HALF;
    assign fin_sum   = q_reg + y_reg + z_reg;
    assign press_sum = x_reg + {p7[59:0], 4'd0};

    assign is_mul = (state_reg == S_M1)  || (state_reg == S_M2)  ||
                    (state_reg == S_M3)  || (state_reg == S_M4)  ||
                    (state_reg == S_M5)  || (state_reg == S_M6)  ||
                    (state_reg == S_M7)  || (state_reg == S_M8)  ||
                    (state_reg == S_M9)  || (state_reg == S_M10) ||
                    (state_reg == S_M11) || (state_reg == S_M12) ||
                    (state_reg == S_M13);

    assign mul_start = is_mul && !issued_reg;
    assign div_start = (state_reg == S_DIV) && !issued_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_M1:    begin mul_a = a_t;   mul_b = t2;  end
            S_M2:    begin mul_a = b_t;   mul_b = b_t; end
            S_M3:    begin mul_a = y_reg; mul_b = t3;  end
            S_M4:    begin mul_a = x_reg; mul_b = x_reg; end
            S_M5:    begin mul_a = y_reg; mul_b = p6;  end
            S_M6:    begin mul_a = x_reg; mul_b = p5;  end
            S_M7:    begin mul_a = y_reg; mul_b = p3;  end
            S_M8:    begin mul_a = x_reg; mul_b = p2;  end
            S_M9:    begin mul_a = w_reg; mul_b = p1;  end
            S_M10:   begin mul_a = x_reg; mul_b = pcomp_pkg::PRESS_SCALE; end
            S_M11:   begin mul_a = q13;   mul_b = p9;  end
            S_M12:   begin mul_a = q13;   mul_b = y_reg; end
            S_M13:   begin mul_a = q_reg; mul_b = p8;  end
            default: begin mul_a = '0;    mul_b = '0;  end
        endcase
    end

    pcomp_mul #(.W(WORD_W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pcomp_div #(.W(WORD_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (x_reg),
        .denom (w_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        adc_p_next   = adc_p_reg;
        adc_t_next   = adc_t_reg;
        rej_next     = rej_reg;
        fault_next   = fault_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        w_next       = w_reg;
        q_next       = q_reg;
        fine_next    = fine_reg;
        held_t_next  = held_t_reg;
        held_p_next  = held_p_reg;
        seen_next    = seen_reg;
        ovalid_next  = ovalid_reg;
        o_t_next     = o_t_reg;
        o_p_next     = o_p_reg;
        o_known_next = o_known_reg;
        o_rej_next   = o_rej_reg;
        o_fault_next = o_fault_reg;

        // drop the result once taken
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (mul_start || div_start)
        begin
            issued_next = 1'b1;
        end
        if (mul_done || div_done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    adc_p_next = in_ch.adc_pressure;
                    adc_t_next = in_ch.adc_temperature;
                    fault_next = 1'b0;
                    rej_next   = (in_ch.adc_pressure == pcomp_pkg::ADC_REJECT) ||
                                 (in_ch.adc_temperature == pcomp_pkg::ADC_REJECT);
                    state_next = ((in_ch.adc_pressure == pcomp_pkg::ADC_REJECT) ||
                                  (in_ch.adc_temperature == pcomp_pkg::ADC_REJECT))
                                 ? S_DONE : S_M1;
                end
            end
            S_M1:
            begin
                if (mul_done)
                begin
                    x_next     = pcomp_pkg::asr(mul_p, 11);
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                if (mul_done)
                begin
                    y_next     = pcomp_pkg::asr(mul_p, 12);
                    state_next = S_M3;
                end
            end
            S_M3:
            begin
                if (mul_done)
                begin
                    fine_next  = x_reg + pcomp_pkg::asr(mul_p, 14);
                    state_next = S_TEMP;
                end
            end
            S_TEMP:
            begin
                // temperature always updates, even if the divide later faults
                held_t_next = 16'(pcomp_pkg::asr(temp_sum, 8));
                x_next      = fine_reg - pcomp_pkg::FINE_OFFSET;
                state_next  = S_M4;
            end
            S_M4:
            begin
                if (mul_done)
                begin
                    y_next     = mul_p;
                    state_next = S_M5;
                end
            end
            S_M5:
            begin
                if (mul_done)
                begin
                    z_next     = mul_p;
                    state_next = S_M6;
                end
            end
            S_M6:
            begin
                if (mul_done)
                begin
                    z_next     = z_reg + {mul_p[46:0], 17'd0} + {p4[28:0], 35'd0};
                    state_next = S_M7;
                end
            end
            S_M7:
            begin
                if (mul_done)
                begin
                    w_next     = pcomp_pkg::asr(mul_p, 8);
                    state_next = S_M8;
                end
            end
            S_M8:
            begin
                if (mul_done)
                begin
                    w_next     = pcomp_pkg::DIV_BASE + w_reg + {mul_p[51:0], 12'd0};
                    state_next = S_M9;
                end
            end
            S_M9:
            begin
                if (mul_done)
                begin
                    w_next     = pcomp_pkg::asr(mul_p, 33);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (w_reg == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    x_next     = ((pcomp_pkg::PRESS_BIAS - {44'd0, adc_p_reg}) << 31)
                                 - z_reg;
                    state_next = S_M10;
                end
            end
            S_M10:
            begin
                if (mul_done)
                begin
                    x_next     = mul_p;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    q_next     = div_q;
                    state_next = S_M11;
                end
            end
            S_M11:
            begin
                if (mul_done)
                begin
                    y_next     = mul_p;
                    state_next = S_M12;
                end
            end
            S_M12:
            begin
                if (mul_done)
                begin
                    y_next     = pcomp_pkg::asr(mul_p, 25);
                    state_next = S_M13;
                end
            end
            S_M13:
            begin
                if (mul_done)
                begin
                    z_next     = pcomp_pkg::asr(mul_p, 19);
                    state_next = S_FIN1;
                end
            end
            S_FIN1:
            begin
                x_next     = pcomp_pkg::asr(fin_sum, 8);
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                // keep the low 32 bits, then whole pascals
                held_p_next = press_sum[31:8];
                seen_next   = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // load the output register when it is free or being taken
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next  = 1'b1;
                    o_t_next     = held_t_reg;
                    o_p_next     = held_p_reg;
                    o_known_next = seen_reg;
                    o_rej_next   = rej_reg;
                    o_fault_next = fault_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            held_t_reg     <= pcomp_pkg::TEMP_RESET;
            held_p_reg     <= '0;
            seen_reg       <= 1'b0;
            ovalid_reg     <= 1'b0;
            temp_cal_reg   <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            held_t_reg <= held_t_next;
            held_p_reg <= held_p_next;
            seen_reg   <= seen_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pcomp_pkg::REG_TEMP_CAL:   temp_cal_reg   <= cfg_data[47:0];
                    pcomp_pkg::REG_PRESS_LOW:  press_low_reg  <= cfg_data;
                    pcomp_pkg::REG_PRESS_HIGH: press_high_reg <= cfg_data;
                    pcomp_pkg::REG_PRESS_NINE: press_nine_reg <= cfg_data[15:0];
                    default:                   press_nine_reg <= press_nine_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        adc_p_reg   <= adc_p_next;
        adc_t_reg   <= adc_t_next;
        rej_reg     <= rej_next;
        fault_reg   <= fault_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        w_reg       <= w_next;
        q_reg       <= q_next;
        fine_reg    <= fine_next;
        o_t_reg     <= o_t_next;
        o_p_reg     <= o_p_next;
        o_known_reg <= o_known_next;
        o_rej_reg   <= o_rej_next;
        o_fault_reg <= o_fault_next;
    end

    assign out_ch.valid             = ovalid_reg;
    assign out_ch.temperature_centi = o_t_reg;
    assign out_ch.pressure_pa       = o_p_reg;
    assign out_ch.pressure_known    = o_known_reg;
    assign out_ch.sample_rejected   = o_rej_reg;
    assign out_ch.divide_fault      = o_fault_reg;

endmodule
